// File: sv/ppmfcd_pkg.sv
// Shared constants, types and the gain coefficient function for the PPM capture decoder.
`timescale 1ns / 1ps

package ppmfcd_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  localparam int TIME_W   = 16;
  localparam int GAP_W    = TIME_W - 1;
  localparam int CH_IDX_W = 3;
  localparam int CH_VAL_W = 13;
  localparam int GAIN_W   = 7;

  // Deviation magnitude from centre: at most 699 us for a valid channel gap.
  localparam int DEV_W = 10;

  // Division by ten is done as a multiplication by ceil(2^19 / 10), exact for
  // products below 2^18. The reciprocal is folded into the gain coefficient.
  localparam int               RECIP_SHIFT = 19;
  localparam logic [15:0]      RECIP_TEN   = 16'd52429;
  localparam int               RECIP_W     = 23;
  localparam int               PROD_W      = DEV_W + RECIP_W;
  localparam int               QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [GAP_W-1:0] SYNC_LOW_US  = 15'd4000;
  localparam logic [GAP_W-1:0] SYNC_HIGH_US = 15'd19000;
  localparam logic [GAP_W-1:0] CHAN_LOW_US  = 15'd800;
  localparam logic [GAP_W-1:0] CHAN_HIGH_US = 15'd2200;
  localparam logic [GAP_W-1:0] CENTER_US    = 15'd1500;

  localparam logic [QUOT_W-1:0] VALUE_LIMIT = 14'd3500;
  localparam logic signed [GAIN_W:0] GAIN_UNITY = 8'sd10;
  localparam logic signed [GAIN_W-1:0] GAIN_TRIM_RESET = 7'sd0;

  // Result buffer depth and its pointer and count widths.
  localparam int OBUF_DEPTH = 3;
  localparam int OBUF_PTR_W = 2;
  localparam int OBUF_CNT_W = 2;

  typedef struct packed {
    logic                valid;
    logic [CH_IDX_W-1:0] index;
    logic [DEV_W-1:0]    dev_mag;
    logic                dev_neg;
  } s1_item_t;

  typedef struct packed {
    logic [CH_IDX_W-1:0]        channel_index;
    logic signed [CH_VAL_W-1:0] channel_value;
  } result_t;

  typedef struct packed {
    logic               neg;
    logic [RECIP_W-1:0] recip;
  } gain_coef_t;

  // Sign and magnitude of (trim + 10), the magnitude pre-multiplied by the
  // reciprocal of ten.
  function automatic gain_coef_t gain_coef(input logic signed [GAIN_W-1:0] trim);
    logic signed [GAIN_W:0] factor;
    logic [GAIN_W:0]        mag;
    gain_coef_t             coef;
    factor     = {trim[GAIN_W-1], trim} + GAIN_UNITY;
    mag        = factor[GAIN_W] ? (GAIN_W+1)'(-factor) : (GAIN_W+1)'(factor);
    coef.neg   = factor[GAIN_W];
    coef.recip = RECIP_W'(mag) * RECIP_W'(RECIP_TEN);
    return coef;
  endfunction

endpackage

// File: sv/ppmfcd_ifs.sv
// Valid/ready channel interfaces for capture timestamps and decoded channels.
`timescale 1ns / 1ps

interface ppmfcd_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppmfcd_pkg::TIME_W-1:0] capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

interface ppmfcd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [ppmfcd_pkg::CH_IDX_W-1:0]       channel_index;
  logic signed [ppmfcd_pkg::CH_VAL_W-1:0] channel_value;

  modport source (output valid, output channel_index, output channel_value, input ready);
  modport sink   (input valid, input channel_index, input channel_value, output ready);
endinterface

// File: sv/ppmfcd_frame.sv
// Gap measurement, pulse classification and frame position tracking.
`timescale 1ns / 1ps

module ppmfcd_frame #(
  parameter int MAX_CHANNELS = ppmfcd_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [ppmfcd_pkg::TIME_W-1:0] capture_time,
  output ppmfcd_pkg::s1_item_t          item
);
  import ppmfcd_pkg::*;

  localparam int POS_BITS = $clog2(MAX_CHANNELS + 2);
  localparam int POS_W    = (POS_BITS > CH_IDX_W) ? POS_BITS : CH_IDX_W;
  localparam logic [POS_W-1:0] POS_IDLE  = '0;
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_CHANNELS);

  logic [TIME_W-1:0]   prev_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                valid_r;
  logic [CH_IDX_W-1:0] index_r;
  logic [DEV_W-1:0]    dev_mag_r;
  logic                dev_neg_r;

  logic [TIME_W-1:0] diff;
  logic [GAP_W-1:0]  gap;
  logic [GAP_W-1:0]  dev_full;
  logic [POS_W-1:0]  pos_m1;
  logic              is_sync, is_chan, armed, emit;

  assign diff     = capture_time - prev_r;
  assign gap      = diff[TIME_W-1:1];
  assign is_sync  = (gap > SYNC_LOW_US) && (gap < SYNC_HIGH_US);
  assign is_chan  = (gap > CHAN_LOW_US) && (gap < CHAN_HIGH_US);
  assign armed    = (pos_r != POS_IDLE) && (pos_r <= POS_LAST);
  assign emit     = accept && !is_sync && armed && is_chan;
  assign pos_m1   = pos_r - POS_FIRST;
  assign dev_full = (gap >= CENTER_US) ? (gap - CENTER_US) : (CENTER_US - gap);

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      priority if (is_sync) begin
        pos_nxt = POS_FIRST;
      end else if (!armed) begin
        pos_nxt = pos_r;
      end else if (is_chan) begin
        pos_nxt = pos_r + POS_FIRST;
      end else begin
        pos_nxt = POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      pos_r   <= POS_IDLE;
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        prev_r <= capture_time;
      end
      pos_r   <= pos_nxt;
      valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      index_r   <= pos_m1[CH_IDX_W-1:0];
      dev_mag_r <= dev_full[DEV_W-1:0];
      dev_neg_r <= (gap < CENTER_US);
    end
  end

  assign item.valid   = valid_r;
  assign item.index   = index_r;
  assign item.dev_mag = dev_mag_r;
  assign item.dev_neg = dev_neg_r;

endmodule

// File: sv/ppmfcd_scale.sv
// Gain register and scaling of the channel deviation by (gain_trim + 10) / 10.
`timescale 1ns / 1ps

module ppmfcd_scale (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic signed [ppmfcd_pkg::GAIN_W-1:0]  cfg_wr_data,
  input  ppmfcd_pkg::s1_item_t                  item,
  output logic                                  res_valid,
  output ppmfcd_pkg::result_t                   res
);
  import ppmfcd_pkg::*;

  gain_coef_t        coef_r;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;
  logic [QUOT_W-1:0] mag;
  logic              neg;

  // The coefficient is worked out once per write, so the item path holds a
  // single multiplier.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= gain_coef(GAIN_TRIM_RESET);
    end else if (cfg_wr_en) begin
      coef_r <= gain_coef(cfg_wr_data);
    end
  end

  assign prod = PROD_W'(item.dev_mag) * PROD_W'(coef_r.recip);
  assign quot = prod[PROD_W-1:RECIP_SHIFT];
  assign mag  = (quot > VALUE_LIMIT) ? VALUE_LIMIT : quot;
  assign neg  = item.dev_neg ^ coef_r.neg;

  assign res_valid         = item.valid;
  assign res.channel_index = item.index;
  assign res.channel_value = neg ? -CH_VAL_W'(mag) : CH_VAL_W'(mag);

endmodule

// File: sv/ppmfcd_obuf.sv
// Three-entry result buffer that decouples the result channel from the input side.
`timescale 1ns / 1ps

module ppmfcd_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ppmfcd_pkg::result_t push_data,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output ppmfcd_pkg::result_t out_data
);
  import ppmfcd_pkg::*;

  localparam logic [OBUF_PTR_W-1:0] PTR_LAST = OBUF_PTR_W'(OBUF_DEPTH - 1);

  result_t                 mem_r [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OBUF_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [OBUF_CNT_W:0]     cnt_sum;
  logic                    pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];

  // A new input may only be taken if the item already in the scaling stage
  // and the one just accepted are both sure of a slot.
  assign cnt_sum = (OBUF_CNT_W+1)'(cnt_r) + (OBUF_CNT_W+1)'(push);
  assign room    = (cnt_sum < (OBUF_CNT_W+1)'(OBUF_DEPTH));

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + OBUF_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - OBUF_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + OBUF_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + OBUF_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/ppm_frame_capture_decoder.sv
// Top level of the PPM frame decoder working from edge capture timestamps.
`timescale 1ns / 1ps

// The decoder takes one timer capture per transfer on in_ch and emits a
// decoded channel on out_ch whenever the gap to the previous capture is a
// valid channel pulse inside an armed frame. A gap of more than 4000 us and
// less than 19000 us is a sync and restarts the frame at channel index 0;
// up to MAX_CHANNELS channels follow, each a gap of more than 800 us and
// less than 2200 us, and any other gap abandons the frame until the next
// sync. Gaps are measured in microseconds from a 16-bit half-microsecond
// timer, so captures may wrap freely. Each channel value is the deviation
// from 1500 us scaled by (gain_trim + 10) / 10, truncated toward zero and
// limited to plus or minus 3500. One capture can be accepted in every clock
// cycle while in_ch.ready is high. The edge of the transfer registers the
// classified gap and the new frame position; the one gain multiplication
// follows in the next cycle, and its result is written into a three-entry
// buffer at the next edge. A result can therefore be taken on out_ch once it
// is in the buffer, and no sooner. in_ch.ready falls when two results
// are held and a third is leaving the scaling stage, which only happens once
// results have backed up behind a low out_ch.ready, and it stays low while
// all three entries are full. gain_trim is written through cfg_wr_en and
// cfg_wr_data and must only change while the decoder is idle.
module ppm_frame_capture_decoder #(
  parameter int MAX_CHANNELS = ppmfcd_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ppmfcd_in_if.sink                            in_ch,
  ppmfcd_out_if.source                         out_ch,
  input  logic                                 cfg_wr_en,
  input  logic signed [ppmfcd_pkg::GAIN_W-1:0] cfg_wr_data
);
  import ppmfcd_pkg::*;

  s1_item_t item;
  result_t  res;
  result_t  out_data;
  logic     res_valid;
  logic     room;
  logic     accept;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  ppmfcd_frame #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .capture_time (in_ch.capture_time),
    .item         (item)
  );

  ppmfcd_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .res_valid   (res_valid),
    .res         (res)
  );

  ppmfcd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.channel_index = out_data.channel_index;
  assign out_ch.channel_value = out_data.channel_value;

endmodule

// File: sv/ppmfcd_checker.sv
// Port-level checks on the PPM decoder and their binding to the top level.
`timescale 1ns / 1ps

module ppmfcd_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [ppmfcd_pkg::CH_IDX_W-1:0]       out_channel_index,
  input logic signed [ppmfcd_pkg::CH_VAL_W-1:0] out_channel_value
);
  import ppmfcd_pkg::*;

  localparam logic signed [CH_VAL_W-1:0] VAL_MAX = CH_VAL_W'(VALUE_LIMIT);

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel_index)
                                && $stable(out_channel_value))
    else $error("result changed while stalled");

  // Values are always saturated to the legal range.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_channel_value <= VAL_MAX) && (out_channel_value >= -VAL_MAX))
    else $error("channel value outside saturation range");

  // The input only stalls when results are backed up on the output.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A result emerging from an empty buffer comes from an earlier input transfer.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transfer");

endmodule

bind ppm_frame_capture_decoder ppmfcd_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_channel_index (out_ch.channel_index),
  .out_channel_value (out_ch.channel_value)
);

// File: sim/ppm_frame_capture_decoder_test.sv
// Self-checking testbench for the PPM frame capture decoder.
`timescale 1ns / 1ps

// The testbench drives timer captures into the decoder and checks every decoded
// channel against a cycle-free predictor kept in step with each input transfer.
// A short directed run covers the following cases:
//   - the first edge after reset, measured against a capture of zero;
//   - a full frame of eight channels with extreme pulse widths;
//   - gaps after the frame is full;
//   - a sync in the middle of a frame;
//   - a bad gap while armed;
//   - gaps while not armed;
//   - the boundary widths of both windows.
// Random frames then follow under a series of gain settings. The settings
// include both ends of the signed 7-bit range, which force the output to
// saturate. Both sides insert random idle cycles, and one phase runs
// without any idling.
module ppm_frame_capture_decoder_test;
  import ppmfcd_pkg::*;

  localparam int MAX_CHANNELS   = MAX_CHANNELS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 190;

  // Window limits in microseconds; both bounds of each window are exclusive.
  localparam int SYNC_MIN_US = 4000;
  localparam int SYNC_MAX_US = 19000;
  localparam int CHAN_MIN_US = 800;
  localparam int CHAN_MAX_US = 2200;
  localparam int CENTRE_US   = 1500;
  localparam int SAT_LIMIT   = 3500;

  typedef struct {
    logic [TIME_W-1:0] stamp;
    bit                drain;  // hold this capture back until no channel is outstanding
  } capture_item_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic signed [GAIN_W-1:0] cfg_wr_data;

  ppmfcd_in_if  in_ch ();
  ppmfcd_out_if out_ch ();

  ppm_frame_capture_decoder #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Captures waiting to be sent, and decoded channels that are due from the block.
  capture_item_t capture_q[$];
  result_t       channel_q[$];

  // The predictor's own copy of the decoder state and of the gain register.
  logic [TIME_W-1:0]        last_stamp;
  int                       frame_pos;
  logic signed [GAIN_W-1:0] gain_trim;

  // The timestamp generator's running capture, which wraps like the real timer.
  logic [TIME_W-1:0] stamp_gen;
  bit                drain_next;

  // Handshake flags.
  // The monitor sets them at the rising edge, and the driver clears them at the
  // falling edge.
  bit in_taken;
  bit out_taken;
  bit fast_send;
  bit fast_recv;
  int send_wait;
  int recv_wait;
  int quiet_cycles;
  int mismatches;
  bit drive_valid;
  bit quiet;
  capture_item_t head;

  int gain_plan[8] = '{-10, 40, 10, -64, 63, -11, 25, 0};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The predictor steps once for every accepted capture.
  // It queues a channel when the gap is a channel pulse inside an armed frame
  // that is not yet full.
  function automatic void decode_capture(input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] ticks;
    int gap_us;
    int scaled;
    result_t chan;
    ticks      = stamp - last_stamp;
    gap_us     = int'(ticks >> 1);
    last_stamp = stamp;
    if (gap_us > SYNC_MIN_US && gap_us < SYNC_MAX_US) begin
      // A sync always re-arms the decoder, even in the middle of a frame.
      frame_pos = 1;
    end else if (frame_pos != 0 && frame_pos <= MAX_CHANNELS) begin
      if (gap_us > CHAN_MIN_US && gap_us < CHAN_MAX_US) begin
        // Signed division truncates toward zero, as the decoder does.
        scaled = ((gap_us - CENTRE_US) * (int'(gain_trim) + 10)) / 10;
        if (scaled > SAT_LIMIT) scaled = SAT_LIMIT;
        if (scaled < -SAT_LIMIT) scaled = -SAT_LIMIT;
        chan.channel_index = CH_IDX_W'(frame_pos - 1);
        chan.channel_value = CH_VAL_W'(scaled);
        channel_q.push_back(chan);
        frame_pos++;
      end else begin
        frame_pos = 0;
      end
    end
    // When the decoder is not armed, or the frame is already full, the gap is
    // ignored.
  endfunction

  // Each side waits a random number of cycles before each transfer.
  // In a fast phase it never waits; otherwise one draw in four is a back-to-back
  // transfer.
  function automatic int draw_wait(input bit fast);
    if (fast || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  // This task queues a capture that lies the given number of microseconds after
  // the previous one. The odd half tick is random, so bit zero of the capture
  // toggles as well.
  task automatic queue_gap(input int gap_us);
    capture_item_t item;
    stamp_gen  = stamp_gen + TIME_W'(2 * gap_us + $urandom_range(0, 1));
    item.stamp = stamp_gen;
    item.drain = drain_next || ($urandom_range(0, 149) == 0);
    drain_next = 1'b0;
    capture_q.push_back(item);
  endtask

  // Most of the traffic is well-formed frames: a sync followed by a full set of
  // channels. The rest is short or long frames, stray syncs and noise gaps
  // that break the frame.
  task automatic queue_frames(input int count);
    int added;
    int channels;
    int pick;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_gap($urandom_range(0, 32767));
        added++;
      end
      if ($urandom_range(0, 7) == 0) queue_gap($urandom_range(0, 1) ? SYNC_MIN_US + 1 :
                                               SYNC_MAX_US - 1);
      else queue_gap($urandom_range(SYNC_MIN_US + 1, SYNC_MAX_US - 1));
      added++;
      channels = ($urandom_range(0, 9) < 7) ? MAX_CHANNELS : $urandom_range(0, MAX_CHANNELS + 3);
      for (int k = 0; k < channels; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) queue_gap(pick < 3 ? CHAN_MIN_US + 1 : pick < 6 ? CHAN_MAX_US - 1 : CENTRE_US);
        else if (pick < 92) queue_gap($urandom_range(CHAN_MIN_US + 1, CHAN_MAX_US - 1));
        else if (pick < 97) queue_gap($urandom_range(0, 32767));
        else queue_gap($urandom_range(SYNC_MIN_US + 1, SYNC_MAX_US - 1));
        added++;
      end
    end
  endtask

  // This task waits until every capture has been sent and every channel has
  // been received. It then allows for a capture that may still be in the
  // pipeline without producing a channel.
  task automatic wait_until_idle;
    while (capture_q.size() != 0 || in_ch.valid || channel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver.
  // Valid falls only when the current capture has been taken and no further
  // capture is ready to follow it at once. A capture that is marked to drain
  // waits until no channel is outstanding.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      drive_valid = in_ch.valid && !in_taken;
      in_taken    = 1'b0;
      if (!drive_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (capture_q.size() != 0 &&
                     !(capture_q[0].drain && channel_q.size() != 0)) begin
          head = capture_q.pop_front();
          in_ch.capture_time <= head.stamp;
          drive_valid = 1'b1;
          send_wait   = draw_wait(fast_send);
        end
      end
      in_ch.valid <= drive_valid;

      if (out_taken) begin
        recv_wait = draw_wait(fast_recv);
        out_taken = 1'b0;
      end
      if (recv_wait > 0) begin
        out_ch.ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor.
  // Input transfers advance the predictor. Output transfers are checked in order
  // against the oldest expected channel. The watchdog counts cycles in which
  // neither side completes a transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      quiet = 1'b1;
      if (in_ch.valid && in_ch.ready) begin
        decode_capture(in_ch.capture_time);
        in_taken = 1'b1;
        quiet    = 1'b0;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_taken = 1'b1;
        quiet     = 1'b0;
        if (channel_q.size() == 0) begin
          $display("%0t: unexpected channel, expected none, got index %0d value %0d",
                   $time, out_ch.channel_index, out_ch.channel_value);
          mismatches++;
        end else begin
          if (out_ch.channel_index !== channel_q[0].channel_index) begin
            $display("%0t: channel_index expected %0d, got %0d", $time,
                     channel_q[0].channel_index, out_ch.channel_index);
            mismatches++;
          end
          if (out_ch.channel_value !== channel_q[0].channel_value) begin
            $display("%0t: channel_value expected %0d, got %0d", $time,
                     channel_q[0].channel_value, out_ch.channel_value);
            mismatches++;
          end
          void'(channel_q.pop_front());
        end
      end
      quiet_cycles = quiet ? quiet_cycles + 1 : 0;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.capture_time = '0;
    out_ch.ready       = 1'b0;
    last_stamp         = '0;
    frame_pos          = 0;
    gain_trim          = '0;
    stamp_gen          = '0;
    mismatches         = 0;
    quiet_cycles       = 0;
    send_wait          = 0;
    recv_wait          = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed part, at the reset gain. The first sync is measured against a
    // capture of zero.
    queue_gap(4500);
    queue_gap(CHAN_MIN_US + 1);
    queue_gap(CHAN_MAX_US - 1);
    queue_gap(CENTRE_US);
    queue_gap(1000);
    queue_gap(2000);
    queue_gap(CENTRE_US - 1);
    queue_gap(CENTRE_US + 1);
    queue_gap(1200);
    // The frame is now full, so these gaps change nothing, including a bad one
    // and one that is just too short for a sync.
    queue_gap(CENTRE_US);
    queue_gap(100);
    queue_gap(SYNC_MIN_US);
    // A sync just inside each end of the window re-arms mid-frame.
    queue_gap(SYNC_MIN_US + 1);
    queue_gap(CENTRE_US);
    queue_gap(SYNC_MAX_US - 1);
    queue_gap(1700);
    // Both channel bounds are excluded, so either one disarms the decoder.
    queue_gap(CHAN_MIN_US);
    queue_gap(CENTRE_US);
    queue_gap(SYNC_MAX_US);
    queue_gap(32767);
    queue_gap(0);
    queue_gap(10000);
    queue_gap(CHAN_MAX_US);

    // Random frames under each gain setting. The first phase holds back one
    // capture until every channel before it has arrived. Two phases run with
    // some or all of the idling switched off.
    for (int p = 0; p < 8; p++) begin
      wait_until_idle();
      @(negedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= (p == 7) ? GAIN_W'($urandom_range(0, 127)) : GAIN_W'(gain_plan[p]);
      gain_trim    = (p == 7) ? cfg_wr_data : GAIN_W'(gain_plan[p]);
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      // The random value was not yet on cfg_wr_data when gain_trim was set above.
      // Refresh the predictor's copy from the port.
      gain_trim  = cfg_wr_data;
      fast_send  = (p == 2);
      fast_recv  = (p == 2 || p == 5);
      drain_next = (p == 0);
      queue_frames(PHASE_ITEMS);
    end

    wait_until_idle();
    repeat (8) @(posedge clk);
    while (channel_q.size() != 0) begin
      $display("%0t: channel index %0d value %0d expected, got none", $time,
               channel_q[0].channel_index, channel_q[0].channel_value);
      void'(channel_q.pop_front());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
